[design/dmsc_pkg.sv]
// Package for the four-digit mode display scanner.
// Shared types and constants; no dependencies.
package dmsc_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int SCAN_W      = $clog2(NUM_DIGITS);
    localparam int DIG_W       = 4;
    localparam int READ_W      = 32;
    localparam int MAG_W       = 14;
    localparam int DWELL_W     = 16;
    localparam int MODE_OH_W   = 3;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 16;

    localparam logic [MAG_W-1:0]   MAG_MAX     = MAG_W'(9999);
    localparam logic [READ_W-1:0]  MAG_LIMIT   = READ_W'(9999);
    localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(1000);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        MODE_PRESSURE,
        MODE_TEMPERATURE,
        MODE_ALTITUDE
    } t_mode;

    typedef struct packed {
        logic              cmd;
        logic              button;
        logic [READ_W-1:0] pressure;
        logic [READ_W-1:0] temperature;
        logic [READ_W-1:0] altitude;
    } t_in_item;

    typedef struct packed {
        t_mode             mode;
        logic [SCAN_W-1:0] scan;
        logic [MAG_W-1:0]  mag;
        logic              neg;
        logic              ovf;
    } t_mid;

endpackage

[design/dmsc_state.sv]
// Display state stage: mode cycling, reading magnitude and saturation, digit scan.
// Uses dmsc_pkg; holds the dwell register and a registered snapshot for the digit stage.
module dmsc_state import dmsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DWELL_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_item,
    output logic               o_valid,
    output t_mid               o_mid,
    input  logic               i_ready
);

    logic [DWELL_W-1:0] r_dwell_ticks;
    t_mode              r_mode,  n_mode;
    logic               r_held,  n_held;
    logic [MAG_W-1:0]   r_mag,   n_mag;
    logic               r_neg,   n_neg;
    logic               r_ovf,   n_ovf;
    logic [SCAN_W-1:0]  r_scan,  n_scan;
    logic [DWELL_W-1:0] r_count, n_count;
    logic               r_valid;
    t_mid               r_mid;

    logic               fire;
    logic [READ_W-1:0]  reading;
    logic [READ_W-1:0]  abs_val;
    logic [DWELL_W-1:0] limit;
    logic [DWELL_W-1:0] count_inc;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_scan    = r_scan;
        n_count   = r_count;
        reading   = '0;
        abs_val   = '0;
        limit     = (r_dwell_ticks == '0) ? DWELL_W'(1) : r_dwell_ticks;
        count_inc = r_count + DWELL_W'(1);
        if (i_item.cmd == CMD_SAMPLE) begin
            if (i_item.button) begin
                if (!r_held) begin
                    case (r_mode)
                        MODE_PRESSURE:    n_mode = MODE_TEMPERATURE;
                        MODE_TEMPERATURE: n_mode = MODE_ALTITUDE;
                        default:          n_mode = MODE_PRESSURE;
                    endcase
                    n_held = 1'b1;
                end
            end else begin
                n_held = 1'b0;
            end
            case (n_mode)
                MODE_PRESSURE:    reading = i_item.pressure;
                MODE_TEMPERATURE: reading = i_item.temperature;
                default:          reading = i_item.altitude;
            endcase
            n_neg   = reading[READ_W-1];
            abs_val = n_neg ? (READ_W'(0) - reading) : reading;
            n_ovf   = abs_val > MAG_LIMIT;
            n_mag   = n_ovf ? MAG_MAX : abs_val[MAG_W-1:0];
        end else begin
            if (count_inc >= limit || count_inc == '0) begin
                n_count = '0;
                n_scan  = r_scan + SCAN_W'(1);
            end else begin
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
        end else if (i_cfg_we) begin
            r_dwell_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PRESSURE;
            r_held  <= 1'b0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_scan  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode  <= n_mode;
                r_held  <= n_held;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_ovf   <= n_ovf;
                r_scan  <= n_scan;
                r_count <= n_count;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mid.mode <= n_mode;
            r_mid.scan <= n_scan;
            r_mid.mag  <= n_mag;
            r_mid.neg  <= n_neg;
            r_mid.ovf  <= n_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_mid   = r_mid;

endmodule

[design/dmsc_digit.sv]
// Digit stage: decimal digit of the scanned position, select pattern, point, flags.
// Uses dmsc_pkg; drives the registered master-side beat.
module dmsc_digit import dmsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_mid                 i_mid,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic [MAG_W-1:0] rem;
    } t_dec_step;

    // leading decimal digit by parallel threshold compares
    function automatic t_dec_step dec_step(input logic [MAG_W-1:0] v,
                                           input logic [MAG_W-1:0] unit);
        t_dec_step        s;
        logic [MAG_W+3:0] th;
        s.digit = '0;
        s.rem   = v;
        th      = (MAG_W+4)'(unit);
        for (int k = 1; k <= 9; k++) begin
            if ((MAG_W+4)'(v) >= th) begin
                s.digit = DIG_W'(k);
                s.rem   = v - th[MAG_W-1:0];
            end
            th = th + (MAG_W+4)'(unit);
        end
        return s;
    endfunction

    t_dec_step        s3, s2, s1;
    logic [DIG_W-1:0] digit_value;
    logic [3:0]       digit_select;
    logic [MODE_OH_W-1:0] mode_onehot;
    logic             point_on;
    logic             fire;
    logic             r_valid;
    logic [M_TDATA_W-1:0] r_tdata;

    assign o_ready = !r_valid || i_m_tready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        s3 = dec_step(i_mid.mag, MAG_W'(1000));
        s2 = dec_step(s3.rem, MAG_W'(100));
        s1 = dec_step(s2.rem, MAG_W'(10));
        case (i_mid.scan)
            2'd0:    begin digit_value = s1.rem[DIG_W-1:0]; digit_select = 4'b0111; end
            2'd1:    begin digit_value = s1.digit;          digit_select = 4'b1011; end
            2'd2:    begin digit_value = s2.digit;          digit_select = 4'b1101; end
            default: begin digit_value = s3.digit;          digit_select = 4'b1110; end
        endcase
        case (i_mid.mode)
            MODE_PRESSURE:    mode_onehot = 3'b001;
            MODE_TEMPERATURE: mode_onehot = 3'b010;
            default:          mode_onehot = 3'b100;
        endcase
        point_on = (i_mid.mode == MODE_TEMPERATURE) && (i_mid.scan == SCAN_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tdata <= {2'b00, i_mid.ovf, i_mid.neg, point_on,
                        digit_value, digit_select, mode_onehot};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;

endmodule

[design/four_digit_mode_display_scanner_unit.sv]
// Top level of the four-digit mode display scanner.
// Uses dmsc_pkg, dmsc_state and dmsc_digit.
//
// Every input beat gives one output beat showing the display after that beat.
// tuser 0 is a sample (button level and three readings), tuser 1 a scan tick.
// One beat is accepted per cycle when not stalled; input register, state stage
// and digit stage each hold their beat under back-pressure. dwell_ticks resets
// to 1000; the user must write it only while the block is idle (not enforced).
module four_digit_mode_display_scanner_unit import dmsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [DWELL_W-1:0]   i_cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] button_pressed, [32:1] pressure, [64:33] temperature,
    // [96:65] altitude, [103:97] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] mode_onehot, [6:3] digit_select, [10:7] digit_value,
    // [11] point_on, [12] negative, [13] overflow, [15:14] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic     r_in_valid;
    t_in_item r_in;
    logic     state_ready;
    logic     mid_valid;
    t_mid     mid;
    logic     digit_ready;

    assign s_tready = !r_in_valid || state_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.cmd         <= s_tuser;
            r_in.button      <= s_tdata[0];
            r_in.pressure    <= s_tdata[32:1];
            r_in.temperature <= s_tdata[64:33];
            r_in.altitude    <= s_tdata[96:65];
        end
    end

    dmsc_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (r_in_valid),
        .o_ready     (state_ready),
        .i_item      (r_in),
        .o_valid     (mid_valid),
        .o_mid       (mid),
        .i_ready     (digit_ready)
    );

    dmsc_digit u_digit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (mid_valid),
        .o_ready    (digit_ready),
        .i_mid      (mid),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule
